>>> sv/vcbss_pkg.sv
// Package: varicode ROM, widths and shared types for the symbol serializer.
`timescale 1ns / 1ps

package vcbss_pkg;

    localparam int CHAR_W    = 8;
    localparam int CODE_W    = 10;   // longest varicode word
    localparam int CNT_W     = 4;    // symbols left in a frame, up to 12
    localparam int IDX_W     = 7;
    localparam int ROM_N     = 95;
    localparam int GAP_N     = 2;

    localparam logic [CHAR_W-1:0] CHAR_EOM   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd126;

    // Right-aligned code bits; entry k is character 32 + k.
    localparam logic [CODE_W-1:0] VC_CODE [0:ROM_N-1] = '{
        10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
        10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
        10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
        10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
        10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
        10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
        10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
        10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
        10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
        10'h02B, 10'h00D, 10'h1EB, 10'h3FB, 10'h01B, 10'h03B, 10'h00F, 10'h007,
        10'h05D, 10'h07F, 10'h015, 10'h017, 10'h005, 10'h037, 10'h077, 10'h03F,
        10'h06D, 10'h07B, 10'h0DF, 10'h1EB, 10'h37B, 10'h15E, 10'h15B
    };

    localparam logic [CNT_W-1:0] VC_LEN [0:ROM_N-1] = '{
        4'd1, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd9,
        4'd8, 4'd8, 4'd9, 4'd9, 4'd7, 4'd6, 4'd7, 4'd9,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9,
        4'd9, 4'd9, 4'd8, 4'd9, 4'd9, 4'd7, 4'd9, 4'd10,
        4'd10, 4'd7, 4'd8, 4'd8, 4'd8, 4'd7, 4'd8, 4'd8,
        4'd9, 4'd7, 4'd9, 4'd9, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd8, 4'd9, 4'd8, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9,
        4'd9, 4'd9, 4'd10, 4'd9, 4'd9, 4'd9, 4'd10, 4'd9,
        4'd10, 4'd4, 4'd7, 4'd6, 4'd6, 4'd2, 4'd6, 4'd7,
        4'd6, 4'd4, 4'd9, 4'd10, 4'd5, 4'd6, 4'd4, 4'd3,
        4'd7, 4'd7, 4'd5, 4'd5, 4'd3, 4'd6, 4'd7, 4'd6,
        4'd7, 4'd7, 4'd8, 4'd9, 4'd10, 4'd9, 4'd9
    };

    // One character's worth of symbols: code left-justified, gap zeros shift in.
    typedef struct packed {
        logic [CODE_W-1:0] sr;
        logic [CNT_W-1:0]  cnt;
        logic              carrier;
    } t_frame;

endpackage

>>> sv/vcbss_in_if.sv
// Character input channel.
`timescale 1ns / 1ps

interface vcbss_in_if;
    import vcbss_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

>>> sv/vcbss_out_if.sv
// Symbol output channel.
`timescale 1ns / 1ps

interface vcbss_out_if;
    logic valid;
    logic ready;
    logic phase_bit;
    logic carrier_on;
    logic last;

    modport source (output valid, output phase_bit, output carrier_on, output last,
                    input ready);
    modport sink   (input valid, input phase_bit, input carrier_on, input last,
                    output ready);
endinterface

>>> sv/vcbss_lookup.sv
// Input register stage: ROM lookup and symbol frame build.
`timescale 1ns / 1ps

module vcbss_lookup (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vcbss_in_if.sink         i_in,
    input  logic             i_take,
    output logic             o_valid,
    output vcbss_pkg::t_frame o_frame
);
    import vcbss_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_frame            r_frame;
    t_frame            n_frame;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  len;

    assign i_in.ready = !r_valid || i_take;
    assign idx = IDX_W'(i_in.char_code - CHAR_FIRST);

    always_comb begin
        len     = VC_LEN[idx];
        n_frame = r_frame;
        n_valid = r_valid && !i_take;
        if (i_in.valid && i_in.ready) begin
            n_frame = '0;
            n_valid = 1'b0;
            if (i_in.char_code == CHAR_EOM) begin
                // carrier off: a single zero-phase symbol
                n_frame.cnt = CNT_W'(1);
                n_valid     = 1'b1;
            end else if (i_in.char_code inside {[CHAR_FIRST:CHAR_LAST]}) begin
                n_frame.sr      = VC_CODE[idx] << (CNT_W'(CODE_W) - len);
                n_frame.cnt     = len + CNT_W'(GAP_N);
                n_frame.carrier = 1'b1;
                n_valid         = 1'b1;
            end
            // characters outside the table are dropped here
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_frame <= n_frame;
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;
endmodule

>>> sv/vcbss_ser.sv
// Output stage: shifts a frame out one symbol per cycle while the receiver is ready.
`timescale 1ns / 1ps

module vcbss_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  vcbss_pkg::t_frame i_frame,
    output logic             o_take,
    vcbss_out_if.source      o_out
);
    import vcbss_pkg::*;

    logic [CODE_W-1:0] r_sr;
    logic [CODE_W-1:0] n_sr;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_carrier;
    logic              n_carrier;
    logic              fire;

    assign fire = o_out.valid && o_out.ready;
    // free now, or handing over the final symbol of this frame
    assign o_take = (r_cnt == '0) || (r_cnt == CNT_W'(1) && o_out.ready);

    always_comb begin
        n_sr      = r_sr;
        n_cnt     = r_cnt;
        n_carrier = r_carrier;
        if (o_take && i_valid) begin
            n_sr      = i_frame.sr;
            n_cnt     = i_frame.cnt;
            n_carrier = i_frame.carrier;
        end else if (fire) begin
            n_sr  = {r_sr[CODE_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_sr      <= n_sr;
        r_carrier <= n_carrier;
    end

    assign o_out.valid      = r_cnt != '0;
    assign o_out.phase_bit  = r_sr[CODE_W-1];
    assign o_out.carrier_on = r_carrier;
    assign o_out.last       = r_cnt == CNT_W'(1);
endmodule

>>> sv/varicode_bpsk_symbol_serializer_top.sv
// Top level: varicode BPSK symbol serializer.
//
// i_in carries one character per item; o_out carries one symbol per item
// (phase_bit, carrier_on, last). A printable character (32..126) becomes
// its varicode bits, MSB first, then two zero-phase gap symbols, last set
// on the second gap symbol. Character 0 becomes one carrier-off symbol with
// last set. Any other character is taken and produces nothing.
//
// The first symbol of a character shows on o_out once the character has
// passed the lookup register and then the shift register load.
// Throughput: one symbol per cycle while o_out.ready holds; a character
// yields code length + 2 symbols (3 to 12), which the serializer's shift
// register and down counter play out. The next character is looked up
// and held while the current one shifts out, and it loads in the cycle
// the final symbol is taken, so frames follow with no gap.
//
// Reset clears both stage valids; nothing is pending afterwards. When the
// receiver stalls the current symbol holds, and once the lookup register
// is full i_in.ready drops until the serializer frees up.
`timescale 1ns / 1ps

module varicode_bpsk_symbol_serializer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vcbss_in_if.sink    i_in,
    vcbss_out_if.source o_out
);
    import vcbss_pkg::*;

    logic   frm_valid;
    logic   frm_take;
    t_frame frm;

    vcbss_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (frm_take),
        .o_valid (frm_valid),
        .o_frame (frm)
    );

    vcbss_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (frm_valid),
        .i_frame (frm),
        .o_take  (frm_take),
        .o_out   (o_out)
    );

    // carrier-off symbol is always the only, final one, with zero phase
    a_eom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.carrier_on) |-> (o_out.last && !o_out.phase_bit))
        else $error("carrier-off symbol not a lone final zero symbol");

    // a taken symbol that is not last must be followed by another one
    a_frame_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("frame ended before its last symbol");

    // a pending frame is never lost while the serializer is busy
    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frm_valid && !frm_take) |=> (frm_valid && $stable(frm)))
        else $error("pending frame dropped or changed");

    // frames hold at least one symbol and never more than twelve
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frm_valid |-> (frm.cnt != '0 && frm.cnt <= CNT_W'(CODE_W + GAP_N)))
        else $error("frame symbol count out of range");
endmodule

>>> tb/varicode_bpsk_symbol_serializer_top_tb.sv
// Testbench: random and directed characters in, varicode symbols checked against a local predictor.
`timescale 1ns / 1ps

module varicode_bpsk_symbol_serializer_top_tb;
    import vcbss_pkg::*;

    typedef struct packed {
        logic phase_bit;
        logic carrier_on;
        logic last;
    } t_sym;

    // Local copy of the code table; entry k is character 32 + k.
    localparam logic [9:0] SYM_CODE [0:94] = '{
        10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
        10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
        10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
        10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
        10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
        10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
        10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
        10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
        10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
        10'h02B, 10'h00D, 10'h1EB, 10'h3FB, 10'h01B, 10'h03B, 10'h00F, 10'h007,
        10'h05D, 10'h07F, 10'h015, 10'h017, 10'h005, 10'h037, 10'h077, 10'h03F,
        10'h06D, 10'h07B, 10'h0DF, 10'h1EB, 10'h37B, 10'h15E, 10'h15B
    };

    localparam int SYM_LEN [0:94] = '{
        1, 9, 9, 9, 9, 10, 10, 9,
        8, 8, 9, 9, 7, 6, 7, 9,
        8, 8, 8, 8, 9, 9, 9, 9,
        9, 9, 8, 9, 9, 7, 9, 10,
        10, 7, 8, 8, 8, 7, 8, 8,
        9, 7, 9, 9, 8, 8, 8, 8,
        8, 9, 8, 7, 7, 9, 9, 9,
        9, 9, 10, 9, 9, 9, 10, 9,
        10, 4, 7, 6, 6, 2, 6, 7,
        6, 4, 9, 10, 5, 6, 4, 3,
        7, 7, 5, 5, 3, 6, 7, 6,
        7, 7, 8, 9, 10, 9, 9
    };

    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 120;   // symbols taken before the long hold
    localparam int TAIL_CYCLES = 40;
    localparam int NUM_ITEMS   = 150;

    logic i_clk;
    logic i_rst_n;

    vcbss_in_if  in_ch ();
    vcbss_out_if out_ch ();

    varicode_bpsk_symbol_serializer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [CHAR_W-1:0] pending_chars [$];
    t_sym              expected_syms [$];
    logic              in_fire;
    logic              out_fire;
    int                errors;
    int                syms_taken;
    int                send_wait;
    int                send_run;
    int                recv_wait;
    int                recv_run;
    logic              hold_done;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_code = '0;
        out_ch.ready = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        errors = 0;
        syms_taken = 0;
        send_wait = 0;
        send_run = 0;
        recv_wait = 0;
        recv_run = 0;
        hold_done = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Per-item wait: drawn at random, with occasional runs of back-to-back items.
    task automatic draw_wait(inout int run_left, output int cycles);
        if (run_left > 0) begin
            run_left--;
            cycles = 0;
        end else if ($urandom_range(0, 7) == 0) begin
            run_left = $urandom_range(5, 40);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 19);
        end
    endtask

    function automatic void predict_symbols(input logic [CHAR_W-1:0] c);
        int   idx;
        t_sym s;
        if (c == CHAR_EOM) begin
            s = '{phase_bit: 1'b0, carrier_on: 1'b0, last: 1'b1};
            expected_syms.push_back(s);
        end else if (c >= CHAR_FIRST && c <= CHAR_LAST) begin
            idx = c - CHAR_FIRST;
            for (int b = SYM_LEN[idx] - 1; b >= 0; b--) begin
                s = '{phase_bit: SYM_CODE[idx][b], carrier_on: 1'b1, last: 1'b0};
                expected_syms.push_back(s);
            end
            s = '{phase_bit: 1'b0, carrier_on: 1'b1, last: 1'b0};
            expected_syms.push_back(s);
            s.last = 1'b1;
            expected_syms.push_back(s);
        end
    endfunction

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Character driver
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (send_wait > 0) begin
                send_wait--;
                in_ch.valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.char_code <= pending_chars.pop_front();
                draw_wait(send_run, send_wait);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Symbol receiver: random stalls plus one long hold while characters keep coming
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_fire)
                draw_wait(recv_run, recv_wait);
            if (!hold_done && syms_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: check symbols against the oldest expectation, then predict new items
    always @(posedge i_clk) begin
        t_sym exp_s;
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        out_fire <= i_rst_n && out_ch.valid && out_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            syms_taken++;
            if (expected_syms.size() == 0) begin
                $display("%0t: unexpected symbol, expected none, actual phase=%b carrier=%b last=%b",
                         $time, out_ch.phase_bit, out_ch.carrier_on, out_ch.last);
                errors++;
            end else begin
                exp_s = expected_syms.pop_front();
                check_field("phase_bit", exp_s.phase_bit, out_ch.phase_bit);
                check_field("carrier_on", exp_s.carrier_on, out_ch.carrier_on);
                check_field("last", exp_s.last, out_ch.last);
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready)
            predict_symbols(in_ch.char_code);
    end

    // Stimulus and end of test
    initial begin
        int pick;
        logic [CHAR_W-1:0] c;

        // space (1-bit code), end of message, ends of printable range, '}' ends in 0,
        // 10-bit codes, shortest letters, unmapped values, back-to-back end of message,
        // duplicate codes ('I' and 'q', 'j' and '{')
        pending_chars = '{8'd32, 8'd0, 8'd126, 8'd125, 8'd107, 8'd37, 8'd101, 8'd1,
                           8'd31, 8'd127, 8'd128, 8'd255, 8'd0, 8'd0, 8'd33, 8'd116,
                           8'd73, 8'd113, 8'd106, 8'd123, 8'd124, 8'd85, 8'd170, 8'd64};
        while (pending_chars.size() < NUM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                c = $urandom_range(CHAR_FIRST, CHAR_LAST);
            end else if (pick < 85) begin
                c = CHAR_EOM;
            end else if (pick < 92) begin
                c = $urandom_range(1, CHAR_FIRST - 1);
            end else begin
                c = $urandom_range(CHAR_LAST + 1, 255);
            end
            pending_chars.push_back(c);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_chars.size() == 0 && !in_ch.valid);
        wait (expected_syms.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
